### design/spol_pkg.sv
// Shared types and codes for the slot pool ordered list.
// Holds the operation and status codes, result field widths and the sequencer states.
// No dependencies.
package spol_pkg;

  localparam int KIND_W   = 2;
  localparam int ENTRY_W  = 7;
  localparam int STATUS_W = 2;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [ENTRY_W-1:0]  entry_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_ALLOC = 2'd0;
  localparam kind_t KIND_FREE  = 2'd1;
  localparam kind_t KIND_QUERY = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_PROTECTED = 2'd2;
  localparam status_t ST_NOT_USED  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WR2  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

endpackage

### design/slot_pool_ordered_list.sv
// Top level of the slot pool ordered list: sequencer, list heads and in-use flags.
// Depends on spol_pkg and spol_link_mem.
//
//   port group      dir   payload                                   handshake
//   in_             in    kind, entry_index                         in_valid / in_ready
//   out_            out   status, entry, next_entry, is_last        out_valid / out_ready
//
// A transaction that changes links steps through accept and read, first link writes,
// second link writes and result. One that changes no links skips the second link
// writes and goes straight to its result. The second link write step is needed
// because each link memory has a single write port.
// The result waits in its register while out_ready is low; no new transaction is
// accepted until it has been taken. Reset is synchronous and active low and restores
// the pool at once: entry 0 active, all others on the free list.
module slot_pool_ordered_list #(
  parameter int ENTRY_COUNT = 128
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  spol_pkg::kind_t          in_kind,
  input  spol_pkg::entry_t         in_entry_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output spol_pkg::status_t        out_status,
  output spol_pkg::entry_t         out_entry,
  output spol_pkg::entry_t         out_next_entry,
  output logic                     out_is_last
);
  import spol_pkg::*;

  localparam int IDX_W  = $clog2(ENTRY_COUNT);
  localparam int LINK_W = $clog2(ENTRY_COUNT + 1);
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(ENTRY_COUNT);

  state_t state_r, state_nxt;

  kind_t             kind_r;
  entry_t            idx_r;
  logic              idx_ok_r;
  logic              in_use_hit_r;
  logic [LINK_W-1:0] free_head_r, free_head_nxt;
  logic [LINK_W-1:0] tail_r, tail_nxt;
  logic [ENTRY_COUNT-1:0] in_use_r, in_use_nxt;

  // Second write, queued during the execute cycle.
  logic              pend_fwd_r, pend_fwd_nxt;
  logic              pend_bk_r, pend_bk_nxt;
  logic [IDX_W-1:0]  pend_addr_r, pend_addr_nxt;
  logic [LINK_W-1:0] pend_data_r, pend_data_nxt;

  status_t status_r, status_nxt;
  entry_t  entry_r, entry_nxt;
  entry_t  next_r, next_nxt;
  logic    last_r, last_nxt;

  logic              accept;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  idx_addr;
  logic [LINK_W-1:0] fwd_q, bk_q;
  logic              fwd_we, bk_we;
  logic [IDX_W-1:0]  fwd_wa, bk_wa;
  logic [LINK_W-1:0] fwd_wd, bk_wd;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign out_status     = status_r;
  assign out_entry      = entry_r;
  assign out_next_entry = next_r;
  assign out_is_last    = last_r;

  // An allocate reads the free head's links; free and query read the named entry.
  assign rd_addr  = (in_kind == KIND_ALLOC) ? IDX_W'(free_head_r) : IDX_W'(in_entry_index);
  assign idx_addr = IDX_W'(idx_r);

  spol_link_mem #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .IDX_W       (IDX_W),
    .LINK_W      (LINK_W)
  ) u_links (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .fwd_rd  (fwd_q),
    .bk_rd   (bk_q),
    .fwd_we  (fwd_we),
    .fwd_wa  (fwd_wa),
    .fwd_wd  (fwd_wd),
    .bk_we   (bk_we),
    .bk_wa   (bk_wa),
    .bk_wd   (bk_wd)
  );

  always_comb begin
    state_nxt     = state_r;
    free_head_nxt = free_head_r;
    tail_nxt      = tail_r;
    in_use_nxt    = in_use_r;
    pend_fwd_nxt  = pend_fwd_r;
    pend_bk_nxt   = pend_bk_r;
    pend_addr_nxt = pend_addr_r;
    pend_data_nxt = pend_data_r;
    status_nxt    = status_r;
    entry_nxt     = entry_r;
    next_nxt      = next_r;
    last_nxt      = last_r;
    fwd_we = 1'b0;
    fwd_wa = '0;
    fwd_wd = '0;
    bk_we  = 1'b0;
    bk_wa  = '0;
    bk_wd  = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        // Defaults describe an error or unknown-kind result with no state change.
        pend_fwd_nxt = 1'b0;
        pend_bk_nxt  = 1'b0;
        status_nxt   = ST_OK;
        entry_nxt    = '0;
        next_nxt     = '0;
        last_nxt     = 1'b0;
        state_nxt    = S_OUT;
        case (kind_r)
          KIND_ALLOC: begin
            if (free_head_r >= END_MARK) begin
              status_nxt = ST_EMPTY;
            end else begin
              // Pop the free head and hang it after the current tail.
              entry_nxt     = ENTRY_W'(free_head_r);
              free_head_nxt = bk_q;
              fwd_we = 1'b1;
              fwd_wa = IDX_W'(free_head_r);
              fwd_wd = END_MARK;
              bk_we  = 1'b1;
              bk_wa  = IDX_W'(free_head_r);
              bk_wd  = tail_r;
              in_use_nxt[IDX_W'(free_head_r)] = 1'b1;
              tail_nxt      = free_head_r;
              pend_fwd_nxt  = 1'b1;
              pend_addr_nxt = IDX_W'(tail_r);
              pend_data_nxt = free_head_r;
              state_nxt     = S_WR2;
            end
          end
          KIND_FREE: begin
            entry_nxt = idx_r;
            if (idx_r == '0) begin
              status_nxt = ST_PROTECTED;
            end else if (!idx_ok_r || !in_use_hit_r) begin
              status_nxt = ST_NOT_USED;
            end else begin
              // Unlink: bk_q is the predecessor, fwd_q the successor.
              if (LINK_W'(idx_r) == tail_r) begin
                tail_nxt = bk_q;
              end else if (fwd_q < END_MARK) begin
                bk_we = 1'b1;
                bk_wa = IDX_W'(fwd_q);
                bk_wd = bk_q;
              end
              if (bk_q < END_MARK) begin
                fwd_we = 1'b1;
                fwd_wa = IDX_W'(bk_q);
                fwd_wd = fwd_q;
              end
              in_use_nxt[idx_addr] = 1'b0;
              // Push onto the free list in the following cycle.
              pend_bk_nxt   = 1'b1;
              pend_addr_nxt = idx_addr;
              pend_data_nxt = free_head_r;
              free_head_nxt = LINK_W'(idx_r);
              state_nxt     = S_WR2;
            end
          end
          KIND_QUERY: begin
            entry_nxt = idx_r;
            if (!idx_ok_r || !in_use_hit_r) begin
              status_nxt = ST_NOT_USED;
            end else if (fwd_q >= END_MARK) begin
              last_nxt = 1'b1;
            end else begin
              next_nxt = ENTRY_W'(fwd_q);
            end
          end
          default: begin
          end
        endcase
      end

      S_WR2: begin
        fwd_we = pend_fwd_r;
        fwd_wa = pend_addr_r;
        fwd_wd = pend_data_r;
        bk_we  = pend_bk_r;
        bk_wa  = pend_addr_r;
        bk_wd  = pend_data_r;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= LINK_W'(1);
      tail_r      <= '0;
      in_use_r    <= ENTRY_COUNT'(1);
      pend_fwd_r  <= 1'b0;
      pend_bk_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      tail_r      <= tail_nxt;
      in_use_r    <= in_use_nxt;
      pend_fwd_r  <= pend_fwd_nxt;
      pend_bk_r   <= pend_bk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r       <= in_kind;
      idx_r        <= in_entry_index;
      idx_ok_r     <= (32'(in_entry_index) < 32'(ENTRY_COUNT));
      in_use_hit_r <= in_use_r[rd_addr];
    end
    pend_addr_r <= pend_addr_nxt;
    pend_data_r <= pend_data_nxt;
    status_r    <= status_nxt;
    entry_r     <= entry_nxt;
    next_r      <= next_nxt;
    last_r      <= last_nxt;
  end

endmodule

### design/spol_link_mem.sv
// Forward and back link memories of the slot pool, one write port each and a
// shared registered read port. Per-entry written bits supply the reset contents.
// No dependencies.
module spol_link_mem #(
  parameter int ENTRY_COUNT = 128,
  parameter int IDX_W       = 7,
  parameter int LINK_W      = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [LINK_W-1:0] fwd_rd,
  output logic [LINK_W-1:0] bk_rd,
  input  logic              fwd_we,
  input  logic [IDX_W-1:0]  fwd_wa,
  input  logic [LINK_W-1:0] fwd_wd,
  input  logic              bk_we,
  input  logic [IDX_W-1:0]  bk_wa,
  input  logic [LINK_W-1:0] bk_wd
);

  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(ENTRY_COUNT);

  logic [LINK_W-1:0] fwd_mem [ENTRY_COUNT];
  logic [LINK_W-1:0] bk_mem  [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] fwd_vld_r;
  logic [ENTRY_COUNT-1:0] bk_vld_r;
  logic [LINK_W-1:0] fwd_data_r;
  logic [LINK_W-1:0] bk_data_r;
  logic              fwd_hit_r;
  logic              bk_hit_r;
  logic [IDX_W-1:0]  rd_addr_r;
  logic [LINK_W-1:0] bk_reset_val;

  always_ff @(posedge clk) begin
    if (fwd_we) begin
      fwd_mem[fwd_wa] <= fwd_wd;
    end
    if (bk_we) begin
      bk_mem[bk_wa] <= bk_wd;
    end
    if (rd_en) begin
      fwd_data_r <= fwd_mem[rd_addr];
      bk_data_r  <= bk_mem[rd_addr];
      rd_addr_r  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= '0;
      bk_vld_r  <= '0;
      fwd_hit_r <= 1'b0;
      bk_hit_r  <= 1'b0;
    end else begin
      if (fwd_we) begin
        fwd_vld_r[fwd_wa] <= 1'b1;
      end
      if (bk_we) begin
        bk_vld_r[bk_wa] <= 1'b1;
      end
      if (rd_en) begin
        fwd_hit_r <= fwd_vld_r[rd_addr];
        bk_hit_r  <= bk_vld_r[rd_addr];
      end
    end
  end

  // Reset contents: forward links all end, back links chain i to i+1 and entry 0 ends.
  assign bk_reset_val = (rd_addr_r == '0) ? END_MARK : (LINK_W'(rd_addr_r) + LINK_W'(1));
  assign fwd_rd = fwd_hit_r ? fwd_data_r : END_MARK;
  assign bk_rd  = bk_hit_r  ? bk_data_r  : bk_reset_val;

endmodule
